// ===== design/cir_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cir_pkg: shared types, constants and functions of the cubic resampler
// Payload structs, datapath widths and sample conversion helpers.
// ----------------------------------------------------------------------------
package cir_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int PHASE_W      = 16;
   localparam int STEP_W       = 21;
   localparam int SKIP_W       = 5;
   localparam int ACC_W        = 20;
   localparam int PROD_W       = ACC_W + PHASE_W + 1;
   localparam int MAX_OUTPUTS  = 8;
   localparam int CNT_W        = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = STEP_W;

   localparam logic [SAMPLE_W-1:0] SIGN_FLIP  = 16'h8000;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'hFFFF;
   localparam logic [SKIP_W-1:0]   SKIP_SAT   = 5'd31;
   localparam logic [SKIP_W-1:0]   SKIP_RESET = 5'd3;
   localparam logic [STEP_W-1:0]   STEP_RESET = 21'h10000;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_RATE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEREO      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REVERSE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGNED_OUT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SIXTEEN_BIT = 3'd4;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] in_left;
      logic signed [SAMPLE_W-1:0] in_right;
   } req_payload_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] out_first;
      logic [SAMPLE_W-1:0] out_second;
      logic                last;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] cur;
      logic signed [ACC_W-1:0] d1;
      logic signed [ACC_W-1:0] d2;
      logic signed [ACC_W-1:0] d3;
   } terms_type;

   // clamp an offset-domain value to 0..65535 and return signed sample bits
   function automatic logic [SAMPLE_W-1:0] clamp_sample(input logic signed [ACC_W-1:0] t);
      logic [SAMPLE_W-1:0] v;
      if (t < 0) begin
         v = '0;
      end else if (t > $signed({{(ACC_W-SAMPLE_W){1'b0}}, SAMPLE_MAX})) begin
         v = SAMPLE_MAX;
      end else begin
         v = t[SAMPLE_W-1:0];
      end
      return v ^ SIGN_FLIP;
   endfunction

   function automatic logic [SAMPLE_W-1:0] format_sample(input logic [SAMPLE_W-1:0] s,
                                                         input logic signed_out,
                                                         input logic sixteen);
      logic [SAMPLE_W-1:0] v;
      v = signed_out ? s : (s ^ SIGN_FLIP);
      if (!sixteen) begin
         v = v >> 8;
      end
      return v;
   endfunction

endpackage

// ===== design/cubic_interpolating_resampler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_interpolating_resampler_core: four-point cubic resampler
// Takes one source frame per transfer and emits 0 to 8 interpolated frames.
// ----------------------------------------------------------------------------
// An input transfer is taken while idle and then produces one result per output
// position that falls before the next source frame. Each result runs through
// states S_M1 to S_M4 per channel on the single shared multiplier (three Horner
// steps and a clamp) and then S_EMIT, which loads the output register and
// waits while the result side stalls. req_stall is high throughout that work.
// The output register lets the next input be taken while the final result
// still waits.
module cubic_interpolating_resampler_core
   import cir_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_M1   = 3'd1;
   localparam logic [2:0] S_M2   = 3'd2;
   localparam logic [2:0] S_M3   = 3'd3;
   localparam logic [2:0] S_M4   = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic                chan_ff, chan_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [SKIP_W-1:0]   skip_ff, skip_in;
   logic [SAMPLE_W-1:0] res_l_ff, res_l_in;
   logic [SAMPLE_W-1:0] res_r_ff, res_r_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_payload_ff, rsp_payload_in;

   logic [STEP_W-1:0]   step_rate_ff;
   logic                stereo_ff, reverse_ff, signed_out_ff, sixteen_ff;

   logic                    accept;
   logic                    emit;
   logic                    emit_last;
   terms_type               terms;
   logic signed [ACC_W-1:0] mul_operand;
   logic signed [ACC_W-1:0] mul_product;
   logic signed [ACC_W-1:0] horner_sum;
   logic [SAMPLE_W-1:0]     clamped;
   logic [STEP_W:0]         phase_sum;
   logic [STEP_W-PHASE_W:0] advance;
   logic [SKIP_W-1:0]       skip_dec;
   logic [SAMPLE_W-1:0]     chan_a, chan_b;

   assign accept = (state_ff == S_IDLE) && req_valid;
   assign emit   = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);

   cir_window u_window (
      .clock    (clock),
      .reset    (reset),
      .shift_en (accept),
      .frame    (req_payload),
      .chan_sel (chan_ff),
      .terms    (terms)
   );

   cir_mulfrac u_mulfrac (
      .clock    (clock),
      .operand  (mul_operand),
      .fraction (phase_ff),
      .product  (mul_product)
   );

   always_comb begin
      case (state_ff)
         S_M2:    mul_operand = mul_product + terms.d2;
         S_M3:    mul_operand = mul_product + terms.d1;
         default: mul_operand = terms.d3;
      endcase
   end

   assign horner_sum = mul_product + terms.cur;
   assign clamped    = clamp_sample(horner_sum);

   assign phase_sum = {{(STEP_W+1-PHASE_W){1'b0}}, phase_ff} + {1'b0, step_rate_ff};
   assign advance   = phase_sum[STEP_W:PHASE_W];
   assign emit_last = (advance != '0) || (cnt_ff == CNT_W'(MAX_OUTPUTS - 1));
   assign skip_dec  = (skip_ff != '0) ? (skip_ff - SKIP_W'(1)) : '0;

   always_comb begin
      if (stereo_ff) begin
         chan_a = reverse_ff ? res_r_ff : res_l_ff;
         chan_b = reverse_ff ? res_l_ff : res_r_ff;
         chan_a = format_sample(chan_a, signed_out_ff, sixteen_ff);
         chan_b = format_sample(chan_b, signed_out_ff, sixteen_ff);
      end else begin
         chan_a = format_sample(res_l_ff, signed_out_ff, sixteen_ff);
         chan_b = '0;
      end
   end

   always_comb begin
      state_in       = state_ff;
      chan_in        = chan_ff;
      cnt_in         = cnt_ff;
      phase_in       = phase_ff;
      skip_in        = skip_ff;
      res_l_in       = res_l_ff;
      res_r_in       = res_r_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               skip_in = skip_dec;
               cnt_in  = '0;
               chan_in = 1'b0;
               if (skip_dec == '0) begin
                  state_in = S_M1;
               end
            end
         end
         S_M1: state_in = S_M2;
         S_M2: state_in = S_M3;
         S_M3: state_in = S_M4;
         S_M4: begin
            if (!chan_ff) begin
               res_l_in = clamped;
               if (stereo_ff) begin
                  chan_in  = 1'b1;
                  state_in = S_M1;
               end else begin
                  state_in = S_EMIT;
               end
            end else begin
               res_r_in = clamped;
               chan_in  = 1'b0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (emit) begin
               rsp_valid_in              = 1'b1;
               rsp_payload_in.out_first  = chan_a;
               rsp_payload_in.out_second = chan_b;
               rsp_payload_in.last       = emit_last;
               phase_in = phase_sum[PHASE_W-1:0];
               skip_in  = (advance > {1'b0, SKIP_SAT}) ? SKIP_SAT : advance[SKIP_W-1:0];
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = emit_last ? S_IDLE : S_M1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         chan_ff       <= 1'b0;
         cnt_ff        <= '0;
         phase_ff      <= '0;
         skip_ff       <= SKIP_RESET;
         rsp_valid_ff  <= 1'b0;
         step_rate_ff  <= STEP_RESET;
         stereo_ff     <= 1'b1;
         reverse_ff    <= 1'b0;
         signed_out_ff <= 1'b1;
         sixteen_ff    <= 1'b1;
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         skip_ff      <= skip_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_STEP_RATE:   step_rate_ff  <= csr_wdata;
               CSR_STEREO:      stereo_ff     <= csr_wdata[0];
               CSR_REVERSE:     reverse_ff    <= csr_wdata[0];
               CSR_SIGNED_OUT:  signed_out_ff <= csr_wdata[0];
               CSR_SIXTEEN_BIT: sixteen_ff    <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      res_l_ff       <= res_l_in;
      res_r_ff       <= res_r_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   a_idle_needs_skip: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE) || (skip_ff != '0))
      else $error("returned to idle with no frames to skip");

   a_emit_continues: assert property (@(posedge clock) disable iff (reset)
      (emit && !emit_last) |=> (state_ff == S_M1) && !chan_ff)
      else $error("sequencer did not restart after non-final result");

   a_mono_second_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !stereo_ff) |-> (rsp_payload.out_second == '0))
      else $error("second channel not zero in mono");

   a_right_only_stereo: assert property (@(posedge clock) disable iff (reset)
      chan_ff |-> stereo_ff)
      else $error("right channel worked on in mono");
`endif

endmodule

// ===== design/cir_mulfrac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cir_mulfrac: shared fractional multiplier
// Registers floor(a * f / 2^16) for a signed operand and a 16-bit phase.
// ----------------------------------------------------------------------------
module cir_mulfrac
   import cir_pkg::*;
(
   input  logic                    clock,
   input  logic signed [ACC_W-1:0] operand,
   input  logic [PHASE_W-1:0]      fraction,
   output logic signed [ACC_W-1:0] product
);

   logic signed [PROD_W-1:0] full_prod;
   logic signed [ACC_W-1:0]  product_ff;
   logic signed [ACC_W-1:0]  product_in;

   assign full_prod  = operand * $signed({1'b0, fraction});
   // arithmetic shift gives the floor
   assign product_in = full_prod[ACC_W+PHASE_W-1:PHASE_W];

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ===== design/cir_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cir_window: four-frame sample windows
// Holds left and right windows and forms the cubic terms of one channel.
// ----------------------------------------------------------------------------
module cir_window
   import cir_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            shift_en,
   input  req_payload_type frame,
   input  logic            chan_sel,
   output terms_type       terms
);

   logic [SAMPLE_W-1:0] left_ff  [4];
   logic [SAMPLE_W-1:0] left_in  [4];
   logic [SAMPLE_W-1:0] right_ff [4];
   logic [SAMPLE_W-1:0] right_in [4];
   logic [SAMPLE_W-1:0] sel      [4];
   logic signed [ACC_W-1:0] o_before, o_cur, o_next, o_after;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         left_in[i]  = left_ff[i];
         right_in[i] = right_ff[i];
      end
      if (shift_en) begin
         for (int i = 0; i < 3; i++) begin
            left_in[i]  = left_ff[i+1];
            right_in[i] = right_ff[i+1];
         end
         left_in[3]  = frame.in_left;
         right_in[3] = frame.in_right;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         if (reset) begin
            left_ff[i]  <= '0;
            right_ff[i] <= '0;
         end else begin
            left_ff[i]  <= left_in[i];
            right_ff[i] <= right_in[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sel[i] = chan_sel ? right_ff[i] : left_ff[i];
      end
   end

   assign o_before = $signed({{(ACC_W-SAMPLE_W){1'b0}}, sel[0] ^ SIGN_FLIP});
   assign o_cur    = $signed({{(ACC_W-SAMPLE_W){1'b0}}, sel[1] ^ SIGN_FLIP});
   assign o_next   = $signed({{(ACC_W-SAMPLE_W){1'b0}}, sel[2] ^ SIGN_FLIP});
   assign o_after  = $signed({{(ACC_W-SAMPLE_W){1'b0}}, sel[3] ^ SIGN_FLIP});

   assign terms.cur = o_cur;
   assign terms.d1  = o_next - o_before;
   assign terms.d2  = (o_before <<< 1) - (o_cur <<< 1) + o_next - o_after;
   assign terms.d3  = o_cur - o_before - o_next + o_after;

endmodule
